// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL; only the back end (srsg_back) includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define SRSG_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, clocked on clk, off during reset.
`define SRSG_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== rtl/srsg_pkg.sv =====
// Shared types, constants and helpers for the serpentine raster sample generator.
package srsg_pkg;

  localparam int MAX_WIDTH   = 256;
  localparam int MAX_HEIGHT  = 256;
  localparam int PIXEL_BITS  = 8;
  localparam int STORE_DEPTH = 65536;
  localparam int STORE_AW    = 16;
  localparam int LEVEL_SHIFT = 4;
  localparam int HALF_LEVEL  = 2048;
  localparam int QUEUE_DEPTH = 2;

  localparam int DIM_W    = 9;
  localparam int ORIGIN_W = 12;
  localparam int LEVEL_W  = 12;
  localparam int GALVO_W  = 13;
  localparam int COUNT_W  = 17;
  localparam int COL_W    = 8;
  localparam int ROW_W    = 9;
  localparam int OP_W     = 2;
  localparam int CFG_AW   = 2;
  localparam int CFG_DW   = 12;
  localparam int OUT_DW   = 56;

  // Input op codes
  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_EMIT  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  // Register indexes
  localparam logic [CFG_AW-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_AW-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_AW-1:0] REG_ORIGIN_X     = 2'd2;
  localparam logic [CFG_AW-1:0] REG_ORIGIN_Y     = 2'd3;

  typedef enum logic [1:0] {
    K_LOAD,
    K_EMIT,
    K_CLEAR
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t              kind;
    logic [PIXEL_BITS-1:0]  pixel;
  } cmd_t;

  typedef struct packed {
    logic [DIM_W-1:0]    image_width;
    logic [DIM_W-1:0]    image_height;
    logic [ORIGIN_W-1:0] origin_x;
    logic [ORIGIN_W-1:0] origin_y;
  } cfg_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               above_half;
    logic [GALVO_W-1:0] galvo_x;
    logic [GALVO_W-1:0] galvo_y;
    logic [COUNT_W-1:0] samples_remaining;
    logic               scan_done;
  } result_t;

  // Dimension as used: zero reads as one, oversize clamps to the maximum.
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                               input logic [DIM_W-1:0] vmax);
    logic [DIM_W-1:0] r;
    if (v == '0) r = DIM_W'(1);
    else if (v > vmax) r = vmax;
    else r = v;
    return r;
  endfunction

endpackage

// ===== rtl/serpentine_raster_sample_gen.sv =====
// Top level of the serpentine raster sample generator: registers, front and back.
//
//   channel  dir  handshake             payload
//   in_      in   in_tvalid/in_tready   tdata: pixel; tuser: op
//   out_     out  out_tvalid/out_tready tdata: level..samples_remaining; tuser: scan_done
//   cfg_     in   cfg_we                cfg_addr register index, cfg_wdata value
//
// The front queue (2 entries) takes one input transfer per cycle while it has room.
// The back end retires a load, a clear or a sample-less emit in S_IDLE; an emit that
// yields a sample goes on to S_ADDR, which reads the store, and S_DATA, which builds
// the sample from registered read data. Sample output sits in a register, so a stalled
// output only blocks the back end once the next sample is ready. rst_n is synchronous;
// it clears the counters, scan position, queue and output valid, not the pixel store.
module serpentine_raster_sample_gen (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [srsg_pkg::PIXEL_BITS-1:0] in_tdata,   // [7:0] pixel
  input  logic [srsg_pkg::OP_W-1:0]       in_tuser,   // [1:0] op
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [11:0] level, [12] above_half, [25:13] galvo_x, [38:26] galvo_y,
  // [55:39] samples_remaining
  output logic [srsg_pkg::OUT_DW-1:0]     out_tdata,
  output logic                            out_tuser,  // [0] scan_done
  input  logic                            cfg_we,
  input  logic [srsg_pkg::CFG_AW-1:0]     cfg_addr,
  input  logic [srsg_pkg::CFG_DW-1:0]     cfg_wdata
);
  import srsg_pkg::*;

  cfg_t    cfg_r, cfg_nxt;
  logic    q_valid;
  cmd_t    q_cmd;
  logic    q_pop;
  result_t res;

  // Register file: write only, fields truncated to their widths
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        REG_IMAGE_WIDTH:  cfg_nxt.image_width  = cfg_wdata[DIM_W-1:0];
        REG_IMAGE_HEIGHT: cfg_nxt.image_height = cfg_wdata[DIM_W-1:0];
        REG_ORIGIN_X:     cfg_nxt.origin_x     = cfg_wdata[ORIGIN_W-1:0];
        REG_ORIGIN_Y:     cfg_nxt.origin_y     = cfg_wdata[ORIGIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{image_width: DIM_W'(1), image_height: DIM_W'(1),
                 origin_x: '0, origin_y: '0};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front: decode and queue
  srsg_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop)
  );

  // Back: store, scan and sample output
  srsg_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  // Pack result fields, lowest field first
  assign out_tdata = {res.samples_remaining, res.galvo_y, res.galvo_x,
                      res.above_half, res.level};
  assign out_tuser = res.scan_done;

endmodule

// ===== rtl/srsg_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module srsg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/srsg_front.sv =====
// Front end: accepts input transfers, decodes the op and queues commands.
module srsg_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [srsg_pkg::PIXEL_BITS-1:0] in_tdata,  // [7:0] pixel
  input  logic [srsg_pkg::OP_W-1:0]     in_tuser,  // [1:0] op
  output logic                          q_valid,
  output srsg_pkg::cmd_t                q_cmd,
  input  logic                          q_pop
);
  import srsg_pkg::*;

  localparam int QIDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t              entry_r [QUEUE_DEPTH];
  logic [QIDX_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QIDX_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  logic      accept;
  logic      push;
  logic      pop;
  cmd_kind_t kind;
  logic      known_op;

  // op decode; the unused code is accepted and dropped
  always_comb begin
    kind     = K_LOAD;
    known_op = 1'b1;
    unique case (in_tuser)
      OP_LOAD:  kind = K_LOAD;
      OP_EMIT:  kind = K_EMIT;
      OP_CLEAR: kind = K_CLEAR;
      default:  known_op = 1'b0;
    endcase
  end

  assign in_tready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign accept    = in_tvalid && in_tready;
  assign push      = accept && known_op;
  assign q_valid   = (count_r != '0);
  assign pop       = q_pop && q_valid;
  assign q_cmd     = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) begin
      entry_r[wr_ptr_r] <= '{kind: kind, pixel: in_tdata};
    end
  end

endmodule

// ===== rtl/srsg_back.sv =====
// Back end: pixel store, scan position, sample generation and output register.
`include "assert_macros.svh"

module srsg_back (
  input  logic              clk,
  input  logic              rst_n,
  input  srsg_pkg::cfg_t    cfg,
  input  logic              q_valid,
  input  srsg_pkg::cmd_t    q_cmd,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output srsg_pkg::result_t out_res
);
  import srsg_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ADDR,
    S_DATA
  } state_t;

  state_t             state_r, state_nxt;
  logic [COUNT_W-1:0] load_count_r, load_count_nxt;
  logic [COUNT_W-1:0] nz_left_r, nz_left_nxt;
  logic [COL_W-1:0]   scan_col_r, scan_col_nxt;
  logic [ROW_W-1:0]   scan_row_r, scan_row_nxt;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [LEVEL_W-1:0] out_level_r, out_level_nxt;
  logic               out_above_r, out_above_nxt;
  logic [GALVO_W-1:0] out_gx_r, out_gx_nxt;
  logic [GALVO_W-1:0] out_gy_r, out_gy_nxt;
  logic [COUNT_W-1:0] out_rem_r, out_rem_nxt;
  logic               out_done_r, out_done_nxt;

  logic [DIM_W-1:0]       w_eff, h_eff;
  logic [2*DIM_W-1:0]     total_full;
  logic [COUNT_W-1:0]     total;
  logic [COL_W-1:0]       w_m1;
  logic [COL_W-1:0]       col_eff;
  logic                   past_end;
  logic                   out_free;
  logic [2*DIM_W-1:0]     lin_addr;
  logic                   ram_we, ram_re;
  logic [PIXEL_BITS-1:0]  ram_rdata;
  logic [LEVEL_W-1:0]     level;
  logic                   nz_dec;
  logic                   out_blank;

  assign w_eff      = eff_dim(cfg.image_width, DIM_W'(MAX_WIDTH));
  assign h_eff      = eff_dim(cfg.image_height, DIM_W'(MAX_HEIGHT));
  assign total_full = w_eff * h_eff;
  assign total      = total_full[COUNT_W-1:0];
  assign w_m1       = COL_W'(w_eff - 1'b1);
  assign col_eff    = (scan_col_r < w_m1) ? scan_col_r : w_m1;
  assign past_end   = (scan_row_r >= h_eff);
  assign out_free   = !out_valid_r || out_ready;
  assign lin_addr   = scan_row_r * w_eff + (2*DIM_W)'(col_r);
  assign level      = LEVEL_W'({ram_rdata, {LEVEL_SHIFT{1'b0}}});
  assign nz_dec     = (ram_rdata != '0) && (nz_left_r != '0);

  srsg_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (load_count_r[STORE_AW-1:0]),
    .wdata (q_cmd.pixel),
    .re    (ram_re),
    .raddr (lin_addr[STORE_AW-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    load_count_nxt = load_count_r;
    nz_left_nxt    = nz_left_r;
    scan_col_nxt   = scan_col_r;
    scan_row_nxt   = scan_row_r;
    col_nxt        = col_r;
    out_valid_nxt  = out_valid_r;
    out_level_nxt  = out_level_r;
    out_above_nxt  = out_above_r;
    out_gx_nxt     = out_gx_r;
    out_gy_nxt     = out_gy_r;
    out_rem_nxt    = out_rem_r;
    out_done_nxt   = out_done_r;
    q_pop          = 1'b0;
    ram_we         = 1'b0;
    ram_re         = 1'b0;

    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          unique case (q_cmd.kind)
            K_CLEAR: begin
              q_pop          = 1'b1;
              load_count_nxt = '0;
              nz_left_nxt    = '0;
              scan_col_nxt   = '0;
              scan_row_nxt   = '0;
            end
            K_LOAD: begin
              q_pop = 1'b1;
              if (load_count_r < total) begin
                ram_we         = 1'b1;
                load_count_nxt = load_count_r + 1'b1;
                if (q_cmd.pixel != '0) nz_left_nxt = nz_left_r + 1'b1;
              end
            end
            K_EMIT: begin
              if (load_count_r < total) begin
                q_pop = 1'b1;  // layer not fully loaded: no sample
              end else if (past_end) begin
                if (out_free) begin
                  q_pop         = 1'b1;
                  out_valid_nxt = 1'b1;
                  out_level_nxt = '0;
                  out_above_nxt = 1'b0;
                  out_gx_nxt    = '0;
                  out_gy_nxt    = '0;
                  out_rem_nxt   = nz_left_r;
                  out_done_nxt  = 1'b1;
                end
              end else begin
                q_pop     = 1'b1;
                col_nxt   = col_eff;
                state_nxt = S_ADDR;
              end
            end
            default: q_pop = 1'b1;
          endcase
        end
      end
      S_ADDR: begin
        ram_re    = 1'b1;
        state_nxt = S_DATA;
      end
      S_DATA: begin
        if (out_free) begin
          nz_left_nxt   = nz_left_r - COUNT_W'(nz_dec);
          out_valid_nxt = 1'b1;
          out_level_nxt = level;
          out_above_nxt = (level > LEVEL_W'(HALF_LEVEL));
          out_gx_nxt    = GALVO_W'(col_r) + GALVO_W'(cfg.origin_x);
          out_gy_nxt    = GALVO_W'(scan_row_r) + GALVO_W'(cfg.origin_y);
          out_rem_nxt   = nz_left_r - COUNT_W'(nz_dec);
          out_done_nxt  = 1'b0;
          if (scan_row_r[0]) begin
            // odd row runs right to left
            if (col_r == '0) scan_row_nxt = scan_row_r + 1'b1;
            else scan_col_nxt = col_r - 1'b1;
          end else begin
            if (col_r >= w_m1) begin
              scan_row_nxt = scan_row_r + 1'b1;
              scan_col_nxt = col_r;
            end else begin
              scan_col_nxt = col_r + 1'b1;
            end
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      load_count_r <= '0;
      nz_left_r    <= '0;
      scan_col_r   <= '0;
      scan_row_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      load_count_r <= load_count_nxt;
      nz_left_r    <= nz_left_nxt;
      scan_col_r   <= scan_col_nxt;
      scan_row_r   <= scan_row_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    col_r       <= col_nxt;
    out_level_r <= out_level_nxt;
    out_above_r <= out_above_nxt;
    out_gx_r    <= out_gx_nxt;
    out_gy_r    <= out_gy_nxt;
    out_rem_r   <= out_rem_nxt;
    out_done_r  <= out_done_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = '{level:             out_level_r,
                       above_half:        out_above_r,
                       galvo_x:           out_gx_r,
                       galvo_y:           out_gy_r,
                       samples_remaining: out_rem_r,
                       scan_done:         out_done_r};

  // blank sample: level and both galvo coordinates at zero
  assign out_blank = (out_level_r == '0) && (out_gx_r == '0) && (out_gy_r == '0);

  `SRSG_ASSERT_IMP(a_nz_le_loaded, 1'b1, nz_left_r <= load_count_r)
  `SRSG_ASSERT_IMP(a_load_bound, 1'b1, load_count_r <= COUNT_W'(STORE_DEPTH))
  `SRSG_ASSERT_IMP(a_done_blank, out_valid_r && out_done_r, out_blank)
  `SRSG_ASSERT_NXT(a_read_follows, state_r == S_ADDR, state_r == S_DATA)

endmodule
